>>> hw/rtl/cltok_pkg.sv
package cltok_pkg;

    // Result kinds
    localparam logic [2:0] KIND_TOKEN_BYTE = 3'd0;
    localparam logic [2:0] KIND_TOKEN_END  = 3'd1;
    localparam logic [2:0] KIND_SENT_BYTE  = 3'd2;
    localparam logic [2:0] KIND_SENT_END   = 3'd3;
    localparam logic [2:0] KIND_ERROR      = 3'd4;
    localparam logic [2:0] KIND_LINE_DONE  = 3'd5;

    // Error codes
    localparam logic [1:0] ERR_NOT_AFTER_BLANK = 2'd0;
    localparam logic [1:0] ERR_BAD_SENT_CHAR   = 2'd1;
    localparam logic [1:0] ERR_EMPTY_SENT      = 2'd2;
    localparam logic [1:0] ERR_BAD_ESCAPE      = 2'd3;

    // Special bytes
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_BS    = 8'h5C;

    // Results per input byte, and the group queue between front and back
    localparam int RES_MAX   = 4;
    localparam int RES_IW    = $clog2(RES_MAX);
    localparam int RES_CW    = $clog2(RES_MAX + 1);
    localparam int RES_NCAND = 5;   // candidate result slots in the front
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [1:0] err;
    } t_res;

    typedef struct packed {
        t_res [RES_MAX-1:0] res;
        logic [RES_CW-1:0]  cnt;
    } t_grp;

    typedef struct packed {
        logic esc;
        logic inq;
        logic blrun;
        logic ltp;
        logic ltab;
        logic insent;
        logic senthas;
        logic tokhas;
        logic prevbl;
        logic linestart;
        logic drop;
    } t_fst;

    localparam t_fst FST_RESET = '{
        esc: 1'b0, inq: 1'b0, blrun: 1'b0, ltp: 1'b0, ltab: 1'b0,
        insent: 1'b0, senthas: 1'b0, tokhas: 1'b0,
        prevbl: 1'b1, linestart: 1'b1, drop: 1'b0
    };

endpackage

>>> hw/rtl/cltok_front.sv
module cltok_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic [7:0]          i_ch,
    input  logic                i_last,
    output logic                o_qpush,
    output cltok_pkg::t_grp     o_grp
);

    cltok_pkg::t_fst r_st;
    cltok_pkg::t_fst n_st;

    // Candidate results in emission order: held '<', byte result,
    // line-end sentinel close, line-end token end, line done.
    cltok_pkg::t_res              cand [cltok_pkg::RES_NCAND];
    logic [cltok_pkg::RES_NCAND-1:0] cand_en;
    logic                         blank;
    logic                         proc;
    logic [cltok_pkg::RES_CW-1:0] cnt;

    assign blank = (i_ch == cltok_pkg::CH_SPACE) || (i_ch == cltok_pkg::CH_TAB);

    always_comb begin
        n_st    = r_st;
        cand_en = '0;
        proc    = 1'b0;
        for (int k = 0; k < cltok_pkg::RES_NCAND; k++) begin
            cand[k] = '0;
        end
        cand[0].kind = cltok_pkg::KIND_TOKEN_BYTE;
        cand[0].data = cltok_pkg::CH_LT;
        cand[4].kind = cltok_pkg::KIND_LINE_DONE;

        if (!r_st.drop) begin
            if (r_st.ltp) begin
                n_st.ltp = 1'b0;
                if (i_ch == cltok_pkg::CH_LT) begin
                    if (!r_st.ltab) begin
                        cand_en[1]  = 1'b1;
                        cand[1].kind = cltok_pkg::KIND_ERROR;
                        cand[1].err  = cltok_pkg::ERR_NOT_AFTER_BLANK;
                        n_st.drop   = 1'b1;
                    end else begin
                        n_st.insent  = 1'b1;
                        n_st.senthas = 1'b0;
                    end
                end else begin
                    cand_en[0]  = 1'b1;
                    n_st.tokhas = 1'b1;
                    proc        = 1'b1;
                end
            end else begin
                proc = 1'b1;
            end

            if (proc && !(n_st.blrun && blank)) begin
                if (!blank) begin
                    n_st.blrun = 1'b0;
                end
                if (n_st.insent) begin
                    cand_en[1] = 1'b1;
                    if (i_ch == cltok_pkg::CH_LT || i_ch == cltok_pkg::CH_DQ ||
                        i_ch == cltok_pkg::CH_BS) begin
                        cand[1].kind = cltok_pkg::KIND_ERROR;
                        cand[1].err  = cltok_pkg::ERR_BAD_SENT_CHAR;
                        n_st.drop    = 1'b1;
                    end else if (blank) begin
                        if (!n_st.senthas) begin
                            cand[1].kind = cltok_pkg::KIND_ERROR;
                            cand[1].err  = cltok_pkg::ERR_EMPTY_SENT;
                            n_st.drop    = 1'b1;
                        end else begin
                            cand[1].kind = cltok_pkg::KIND_SENT_END;
                            n_st.insent  = 1'b0;
                            n_st.senthas = 1'b0;
                            n_st.blrun   = 1'b1;
                        end
                    end else begin
                        cand[1].kind = cltok_pkg::KIND_SENT_BYTE;
                        cand[1].data = i_ch;
                        n_st.senthas = 1'b1;
                    end
                end else if (i_ch == cltok_pkg::CH_LT) begin
                    if (n_st.esc || i_last) begin
                        n_st.esc     = 1'b0;
                        cand_en[1]   = 1'b1;
                        cand[1].kind = cltok_pkg::KIND_TOKEN_BYTE;
                        cand[1].data = i_ch;
                        n_st.tokhas  = 1'b1;
                    end else begin
                        n_st.ltp  = 1'b1;
                        n_st.ltab = r_st.prevbl;
                    end
                end else if (i_ch == cltok_pkg::CH_BS || i_ch == cltok_pkg::CH_DQ) begin
                    if (n_st.esc) begin
                        n_st.esc     = 1'b0;
                        cand_en[1]   = 1'b1;
                        cand[1].kind = cltok_pkg::KIND_TOKEN_BYTE;
                        cand[1].data = i_ch;
                        n_st.tokhas  = 1'b1;
                    end else if (i_ch == cltok_pkg::CH_BS) begin
                        n_st.esc = 1'b1;
                    end else begin
                        n_st.inq = ~n_st.inq;
                    end
                end else if (n_st.esc) begin
                    // escape before a blank or an ordinary byte
                    cand_en[1]   = 1'b1;
                    cand[1].kind = cltok_pkg::KIND_ERROR;
                    cand[1].err  = cltok_pkg::ERR_BAD_ESCAPE;
                    n_st.drop    = 1'b1;
                end else if (blank && !n_st.inq) begin
                    if (!r_st.linestart) begin
                        cand_en[1]   = 1'b1;
                        cand[1].kind = cltok_pkg::KIND_TOKEN_END;
                    end
                    n_st.tokhas = 1'b0;
                    n_st.blrun  = 1'b1;
                end else begin
                    cand_en[1]   = 1'b1;
                    cand[1].kind = cltok_pkg::KIND_TOKEN_BYTE;
                    cand[1].data = i_ch;
                    n_st.tokhas  = 1'b1;
                end
            end

            n_st.prevbl    = blank;
            n_st.linestart = 1'b0;
        end

        if (i_last) begin
            if (!n_st.drop && n_st.insent) begin
                cand_en[2] = 1'b1;
                if (n_st.senthas) begin
                    cand[2].kind = cltok_pkg::KIND_SENT_END;
                end else begin
                    cand[2].kind = cltok_pkg::KIND_ERROR;
                    cand[2].err  = cltok_pkg::ERR_EMPTY_SENT;
                    n_st.drop    = 1'b1;
                end
            end
            if (!n_st.drop && n_st.tokhas) begin
                cand_en[3]   = 1'b1;
                cand[3].kind = cltok_pkg::KIND_TOKEN_END;
            end
            cand_en[4] = 1'b1;
            n_st       = cltok_pkg::FST_RESET;
        end
    end

    // Pack the enabled candidates into consecutive slots.
    always_comb begin
        cnt   = '0;
        o_grp = '0;
        for (int k = 0; k < cltok_pkg::RES_NCAND; k++) begin
            if (cand_en[k] && (cnt < cltok_pkg::RES_CW'(cltok_pkg::RES_MAX))) begin
                o_grp.res[cnt[cltok_pkg::RES_IW-1:0]] = cand[k];
                cnt = cnt + 1'b1;
            end
        end
        o_grp.cnt = cnt;
    end

    assign o_qpush = i_acc && (cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= cltok_pkg::FST_RESET;
        end else if (i_acc) begin
            r_st <= n_st;
        end
    end

endmodule

>>> hw/rtl/cltok_queue.sv
module cltok_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cltok_pkg::t_grp     i_grp,
    output logic                o_full,
    input  logic                i_pop,
    output cltok_pkg::t_grp     o_head,
    output logic                o_empty
);

    cltok_pkg::t_grp             r_mem [cltok_pkg::QDEPTH];
    logic [cltok_pkg::QAW-1:0]   r_wp;
    logic [cltok_pkg::QAW-1:0]   r_rp;
    logic [cltok_pkg::QAW:0]     r_cnt;
    logic                        wr;
    logic                        rd;

    assign o_full  = (r_cnt == (cltok_pkg::QAW+1)'(cltok_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (cltok_pkg::QAW+1)'(wr) - (cltok_pkg::QAW+1)'(rd);
        end
    end

endmodule

>>> hw/rtl/cltok_back.sv
module cltok_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_qempty,
    input  cltok_pkg::t_grp     i_qhead,
    output logic                o_qpop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [2:0]          o_kind,
    output logic [7:0]          o_data,
    output logic [1:0]          o_error_code,
    output logic                o_run_last
);

    logic                          r_valid;
    cltok_pkg::t_grp               r_grp;
    logic [cltok_pkg::RES_IW-1:0]  r_idx;
    logic                          is_last;
    logic                          take;
    cltok_pkg::t_res               cur;

    assign cur     = r_grp.res[r_idx];
    assign is_last = ((cltok_pkg::RES_CW)'(r_idx) + 1'b1) == r_grp.cnt;
    // Load the next group when none is held, or once the current one has given its last beat.
    assign take    = !r_valid || (i_pop && is_last);
    assign o_qpop  = take && !i_qempty;

    assign o_empty      = !r_valid;
    assign o_kind       = cur.kind;
    assign o_data       = cur.data;
    assign o_error_code = cur.err;
    assign o_run_last   = is_last;

    always_ff @(posedge i_clk) begin
        if (o_qpop) begin
            r_grp <= i_qhead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (take) begin
            r_valid <= !i_qempty;
            r_idx   <= '0;
        end else if (i_pop) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

>>> hw/rtl/command_line_tokenizer.sv
// Channel   Handshake               Payload
// input     push / full             i_ch[7:0], i_line_last
// result    pop / empty             o_kind[2:0], o_data[7:0], o_error_code[1:0], o_run_last
//
// One byte is accepted per cycle while full is low; its 0 to 4 results are
// classified in that same cycle and, if any, written as one group into a 4-deep queue.
// The back end drains one result beat per cycle while pop is high; full rises
// only when the group queue fills. The first result of a byte passes through
// the group queue and the back end's group register before reaching the ports.
// Reset (i_rst_n low at a clock edge) clears the control state and empties the queue.
module command_line_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_ch,
    input  logic        i_line_last,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data,
    output logic [1:0]  o_error_code,
    output logic        o_run_last
);

    logic            acc;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    cltok_pkg::t_grp f_grp;
    cltok_pkg::t_grp q_head;

    // Accept a beat whenever the group queue has room.
    assign full = q_full;
    assign acc  = push && !q_full;

    // Front: track quote/escape/blank/sentinel state, build the result group.
    cltok_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_ch    (i_ch),
        .i_last  (i_line_last),
        .o_qpush (q_push),
        .o_grp   (f_grp)
    );

    // Decouple front and back so each side can stall on its own.
    cltok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_grp   (f_grp),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    // Back: hold a group and hand out its results one beat at a time.
    cltok_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qempty     (q_empty),
        .i_qhead      (q_head),
        .o_qpop       (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_kind       (o_kind),
        .o_data       (o_data),
        .o_error_code (o_error_code),
        .o_run_last   (o_run_last)
    );

`ifndef SYNTHESIS
    // Queued groups never carry zero results.
    a_grp_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_empty |-> (q_head.cnt != '0))
        else $error("empty result group in queue");

    // Line done always closes the run of its byte.
    a_line_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == cltok_pkg::KIND_LINE_DONE) |-> o_run_last)
        else $error("line done not last result of its byte");

    // Only byte-carrying kinds have nonzero data.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != cltok_pkg::KIND_TOKEN_BYTE &&
         o_kind != cltok_pkg::KIND_SENT_BYTE) |-> (o_data == 8'd0))
        else $error("nonzero data on non-byte result");
`endif

endmodule

>>> verif/tb_command_line_tokenizer.sv
`timescale 1ns / 1ps

module tb_command_line_tokenizer;

    // Expected result beat: the packed result plus the end-of-byte marker
    typedef struct {
        logic [2:0] kind;
        logic [7:0] data;
        logic [1:0] err;
        logic       run_last;
    } t_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_ch;
    logic       i_line_last;
    logic       empty;
    logic       pop;
    logic [2:0] o_kind;
    logic [7:0] o_data;
    logic [1:0] o_error_code;
    logic       o_run_last;

    command_line_tokenizer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_ch         (i_ch),
        .i_line_last  (i_line_last),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_data       (o_data),
        .o_error_code (o_error_code),
        .o_run_last   (o_run_last)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Tokenizer state as tracked by the predictor; cleared after every line done
    cltok_pkg::t_fst tok_state = cltok_pkg::FST_RESET;
    cltok_pkg::t_res byte_results[$];    // results of the byte being predicted
    t_beat           pending_beats[$];   // every beat still owed by the block
    logic [7:0]      line_buf[$];        // the line about to be sent

    int unsigned snd_idle_max = 11;
    int unsigned rcv_idle_max = 11;
    int unsigned hold_cycles  = 0;   // long receiver hold-off, picked up by the drain
    bit          rst_done     = 1'b0;

    int unsigned err_count     = 0;
    int unsigned bytes_sent    = 0;
    int unsigned lines_sent    = 0;
    int unsigned beats_checked = 0;
    int unsigned kind_seen[6];

    task automatic report_error(input string msg);
        err_count++;
        $display("ERROR @%0t ns: %s", $time, msg);
    endtask

    // Append one byte to the line being built
    function automatic void put_byte(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Append one result; a byte never produces more than RES_MAX of them
    function automatic void add_result(input logic [2:0] kind, input logic [7:0] data,
                                       input logic [1:0] err);
        cltok_pkg::t_res r;
        r.kind = kind;
        r.data = data;
        r.err  = err;
        if (byte_results.size() < cltok_pkg::RES_MAX)
            byte_results.insert(byte_results.size(), r);
    endfunction

    // An error drops everything up to the line's last byte
    function automatic void raise_error(input logic [1:0] err);
        add_result(cltok_pkg::KIND_ERROR, 8'h00, err);
        tok_state.drop = 1'b1;
    endfunction

    function automatic void add_token_byte(input logic [7:0] c);
        add_result(cltok_pkg::KIND_TOKEN_BYTE, c, 2'd0);
        tok_state.tokhas = 1'b1;
    endfunction

    // Handle one byte that is not the second half of a held '<'
    function automatic void classify_byte(input logic [7:0] c, input logic last);
        logic blank;
        blank = (c == cltok_pkg::CH_SPACE) || (c == cltok_pkg::CH_TAB);

        // only the first blank of an unquoted run acts
        if (tok_state.blrun && blank)
            return;
        if (!blank)
            tok_state.blrun = 1'b0;

        if (tok_state.insent) begin
            if (c == cltok_pkg::CH_LT || c == cltok_pkg::CH_DQ || c == cltok_pkg::CH_BS) begin
                raise_error(cltok_pkg::ERR_BAD_SENT_CHAR);
                return;
            end
            if (blank) begin
                if (!tok_state.senthas) begin
                    raise_error(cltok_pkg::ERR_EMPTY_SENT);
                    return;
                end
                // a blank closing a mark opens a skipped run and ends no token
                add_result(cltok_pkg::KIND_SENT_END, 8'h00, 2'd0);
                tok_state.insent  = 1'b0;
                tok_state.senthas = 1'b0;
                tok_state.blrun   = 1'b1;
                return;
            end
            add_result(cltok_pkg::KIND_SENT_BYTE, c, 2'd0);
            tok_state.senthas = 1'b1;
            return;
        end

        if (c == cltok_pkg::CH_LT) begin
            if (tok_state.esc) begin
                tok_state.esc = 1'b0;
                add_token_byte(c);
            end else if (last) begin
                add_token_byte(c);
            end else begin
                // hold the '<' one byte to look for a second one
                tok_state.ltp  = 1'b1;
                tok_state.ltab = tok_state.prevbl;
            end
        end else if (c == cltok_pkg::CH_BS) begin
            if (tok_state.esc) begin
                tok_state.esc = 1'b0;
                add_token_byte(c);
            end else begin
                tok_state.esc = 1'b1;
            end
        end else if (c == cltok_pkg::CH_DQ) begin
            if (tok_state.esc) begin
                tok_state.esc = 1'b0;
                add_token_byte(c);
            end else begin
                tok_state.inq = !tok_state.inq;
            end
        end else if (blank) begin
            if (tok_state.esc) begin
                raise_error(cltok_pkg::ERR_BAD_ESCAPE);
                return;
            end
            if (tok_state.inq) begin
                add_token_byte(c);
            end else begin
                // ends even an empty token, except at the line start
                if (!tok_state.linestart)
                    add_result(cltok_pkg::KIND_TOKEN_END, 8'h00, 2'd0);
                tok_state.tokhas = 1'b0;
                tok_state.blrun  = 1'b1;
            end
        end else begin
            if (tok_state.esc) begin
                raise_error(cltok_pkg::ERR_BAD_ESCAPE);
                return;
            end
            add_token_byte(c);
        end
    endfunction

    // Work out the beats caused by one accepted byte and queue them
    function automatic void predict_byte(input logic [7:0] c, input logic last);
        logic  blank;
        t_beat b;
        blank = (c == cltok_pkg::CH_SPACE) || (c == cltok_pkg::CH_TAB);
        byte_results.delete();

        if (!tok_state.drop) begin
            if (tok_state.ltp) begin
                tok_state.ltp = 1'b0;
                if (c == cltok_pkg::CH_LT) begin
                    if (!tok_state.ltab) begin
                        raise_error(cltok_pkg::ERR_NOT_AFTER_BLANK);
                    end else begin
                        tok_state.insent  = 1'b1;
                        tok_state.senthas = 1'b0;
                    end
                end else begin
                    // a lone held '<' goes out before the new byte is handled
                    add_token_byte(cltok_pkg::CH_LT);
                    classify_byte(c, last);
                end
            end else begin
                classify_byte(c, last);
            end
            tok_state.prevbl    = blank;
            tok_state.linestart = 1'b0;
        end

        if (last) begin
            // close an open mark, then a token with bytes; a dangling
            // escape or quote is ignored
            if (!tok_state.drop && tok_state.insent) begin
                if (tok_state.senthas)
                    add_result(cltok_pkg::KIND_SENT_END, 8'h00, 2'd0);
                else
                    raise_error(cltok_pkg::ERR_EMPTY_SENT);
            end
            if (!tok_state.drop && tok_state.tokhas)
                add_result(cltok_pkg::KIND_TOKEN_END, 8'h00, 2'd0);
            add_result(cltok_pkg::KIND_LINE_DONE, 8'h00, 2'd0);
            tok_state = cltok_pkg::FST_RESET;
        end

        foreach (byte_results[i]) begin
            b.kind     = byte_results[i].kind;
            b.data     = byte_results[i].data;
            b.err      = byte_results[i].err;
            b.run_last = (i == byte_results.size() - 1);
            pending_beats.insert(pending_beats.size(), b);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one byte after a random gap; predict once it is taken
    task automatic send_byte(input logic [7:0] c, input logic last);
        int unsigned gap;
        gap = $urandom_range(snd_idle_max, 0);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_ch        <= c;
        i_line_last <= last;
        // full is read just after the edge, i.e. the value the block saw
        do @(posedge i_clk); while (full);
        predict_byte(c, last);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_byte(line_buf[i], i == line_buf.size() - 1);
        lines_sent++;
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        foreach (s[i])
            put_byte(s[i]);
        send_line();
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic check_result();
        t_beat want;
        if (pending_beats.size() == 0) begin
            report_error($sformatf("unexpected beat kind=%0d data=%02h err=%0d last=%0b",
                                   o_kind, o_data, o_error_code, o_run_last));
            return;
        end
        want = pending_beats.pop_front();
        if (o_kind !== want.kind)
            report_error($sformatf("beat %0d: kind %0d, want %0d",
                                   beats_checked, o_kind, want.kind));
        if (o_data !== want.data)
            report_error($sformatf("beat %0d: data %02h, want %02h",
                                   beats_checked, o_data, want.data));
        if (o_error_code !== want.err)
            report_error($sformatf("beat %0d: error_code %0d, want %0d",
                                   beats_checked, o_error_code, want.err));
        if (o_run_last !== want.run_last)
            report_error($sformatf("beat %0d: run_last %0b, want %0b",
                                   beats_checked, o_run_last, want.run_last));
        if (want.kind <= cltok_pkg::KIND_LINE_DONE)
            kind_seen[want.kind]++;
        beats_checked++;
    endtask

    // Drain results with random stalls; a requested hold-off is counted here
    initial begin : result_drain
        int unsigned gap;
        pop <= 1'b0;
        wait (rst_done);
        forever begin
            if (hold_cycles != 0) begin
                pop <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            gap = $urandom_range(rcv_idle_max, 0);
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            check_result();
        end
    end

    // ------------------------------------------------------------------
    // Random line builder
    // ------------------------------------------------------------------

    function automatic logic [7:0] blank_char();
        return ($urandom_range(1, 0) != 0) ? cltok_pkg::CH_SPACE : cltok_pkg::CH_TAB;
    endfunction

    // Printable byte with no special meaning
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(126, 33));
        while (c == cltok_pkg::CH_LT || c == cltok_pkg::CH_DQ || c == cltok_pkg::CH_BS);
        return c;
    endfunction

    function automatic void add_word(input int unsigned n_min, input int unsigned n_max);
        int unsigned n;
        n = $urandom_range(n_max, n_min);
        repeat (n)
            put_byte(word_char());
    endfunction

    // Mostly well-formed words, quotes, escapes and marks; some noise
    function automatic void build_random_line();
        int unsigned parts;
        int unsigned pick;
        line_buf.delete();
        parts = $urandom_range(4, 1);
        if ($urandom_range(5, 0) == 0)
            put_byte(blank_char());
        for (int p = 0; p < parts; p++) begin
            if (p != 0)
                repeat ($urandom_range(2, 1)) put_byte(blank_char());
            case ($urandom_range(9, 0))
                0, 1, 2: add_word(1, 5);
                3: begin
                    // quoted word, sometimes with blanks inside
                    put_byte(cltok_pkg::CH_DQ);
                    add_word(0, 3);
                    if ($urandom_range(1, 0) != 0) begin
                        put_byte(blank_char());
                        add_word(0, 2);
                    end
                    if ($urandom_range(4, 0) != 0)
                        put_byte(cltok_pkg::CH_DQ);
                end
                4: begin
                    add_word(0, 2);
                    put_byte(cltok_pkg::CH_BS);
                    pick = $urandom_range(5, 0);
                    if (pick == 0)      put_byte(cltok_pkg::CH_LT);
                    else if (pick == 1) put_byte(cltok_pkg::CH_DQ);
                    else if (pick == 2) put_byte(cltok_pkg::CH_BS);
                    else if (pick == 3) put_byte(blank_char());
                    else if (pick == 4) put_byte(word_char());
                    // otherwise leave the escape dangling, maybe at the line end
                end
                5, 6: begin
                    // here-doc mark; now and then empty or with a bad byte
                    put_byte(cltok_pkg::CH_LT);
                    put_byte(cltok_pkg::CH_LT);
                    if ($urandom_range(5, 0) != 0)
                        add_word(1, 4);
                    if ($urandom_range(7, 0) == 0)
                        put_byte(($urandom_range(1, 0) != 0) ? cltok_pkg::CH_DQ
                                                             : cltok_pkg::CH_BS);
                end
                7: begin
                    // lone '<' or a '<<' glued to a word
                    add_word(0, 2);
                    put_byte(cltok_pkg::CH_LT);
                    if ($urandom_range(2, 0) == 0)
                        put_byte(cltok_pkg::CH_LT);
                    add_word(0, 2);
                end
                default: begin
                    repeat ($urandom_range(3, 1))
                        put_byte(8'($urandom_range(255, 0)));
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Leading blank, empty quoted token, mark after a blank, top byte value
    task automatic test_blanks_and_mark();
        line_buf = '{cltok_pkg::CH_TAB, cltok_pkg::CH_DQ, cltok_pkg::CH_DQ,
                     cltok_pkg::CH_SPACE, cltok_pkg::CH_LT, cltok_pkg::CH_LT, 8'hFF};
        send_line();
    endtask

    // Literal escapes, blank run, '<' as the last byte; bad escapes
    task automatic test_escapes();
        send_text("\\<\\\"\\\\ \t<");
        send_text("\\ ");
        line_buf = '{cltok_pkg::CH_BS, 8'h00};
        send_line();
    endtask

    // Lone '<' flushed before a letter, then '<<' not after a blank
    task automatic test_held_lt();
        send_text("<b<<");
    endtask

    // Bad byte inside a mark, mark closed empty by a blank and by the line end
    task automatic test_mark_errors();
        send_text("<<a\"");
        send_text("<< ");
        send_text("<<");
    endtask

    // Open quote and dangling escape at the line end
    task automatic test_line_end();
        send_text("\"a\\");
    endtask

    // Hold the drain off while bytes keep coming so the input stalls
    task automatic test_full_stall();
        int unsigned start;
        snd_idle_max = 0;
        rcv_idle_max = 0;
        hold_cycles  = 150;
        start = bytes_sent;
        while (bytes_sent - start < 48) begin
            build_random_line();
            send_line();
        end
        snd_idle_max = 11;
        rcv_idle_max = 11;
    endtask

    // Random lines in stretches of differing idle patterns on both sides
    task automatic test_random_lines();
        int unsigned start;
        int unsigned seg_start;
        start     = bytes_sent;
        seg_start = bytes_sent;
        while (bytes_sent - start < 316) begin
            if (bytes_sent - seg_start >= 40) begin
                seg_start = bytes_sent;
                case ($urandom_range(3, 0))
                    0: begin snd_idle_max = 0;  rcv_idle_max = 0;  end
                    1: begin snd_idle_max = 0;  rcv_idle_max = 11; end
                    2: begin snd_idle_max = 11; rcv_idle_max = 0;  end
                    default: begin snd_idle_max = 11; rcv_idle_max = 11; end
                endcase
            end
            build_random_line();
            send_line();
        end
        snd_idle_max = 11;
        rcv_idle_max = 11;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : main_seq
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_ch        <= 8'h00;
        i_line_last <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        test_blanks_and_mark();
        test_escapes();
        test_held_lt();
        test_mark_errors();
        test_line_end();
        test_full_stall();
        test_random_lines();

        push <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge i_clk);
        // catch stray beats after the last expected one
        repeat (30) @(posedge i_clk);

        $display("tb: %0d bytes in %0d lines, %0d beats; token bytes %0d, ends %0d",
                 bytes_sent, lines_sent, beats_checked,
                 kind_seen[cltok_pkg::KIND_TOKEN_BYTE], kind_seen[cltok_pkg::KIND_TOKEN_END]);
        $display("tb: mark bytes %0d, mark ends %0d, block errors %0d, lines done %0d",
                 kind_seen[cltok_pkg::KIND_SENT_BYTE], kind_seen[cltok_pkg::KIND_SENT_END],
                 kind_seen[cltok_pkg::KIND_ERROR], kind_seen[cltok_pkg::KIND_LINE_DONE]);
        if (err_count == 0)
            $display("tb_command_line_tokenizer: clean");
        else
            $display("tb_command_line_tokenizer: errors");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("tb: timeout with %0d beats still expected", pending_beats.size());
        $display("tb_command_line_tokenizer: errors");
        $finish;
    end

endmodule

>>> command_line_tokenizer.f
hw/rtl/cltok_pkg.sv
hw/rtl/cltok_front.sv
hw/rtl/cltok_queue.sv
hw/rtl/cltok_back.sv
hw/rtl/command_line_tokenizer.sv
verif/tb_command_line_tokenizer.sv
